@@ design/rlis_pkg.sv @@
// Shared types and constants for the run-length indexed store.
`timescale 1ns / 1ps
`default_nettype none
package rlis_pkg;

   localparam int RUN_SLOTS   = 64;
   localparam int LENGTH_BITS = 16;
   localparam int SLOT_BITS   = $clog2(RUN_SLOTS + 1);
   localparam int POS_BITS    = 16;
   localparam int CMP_BITS    = (LENGTH_BITS > POS_BITS) ? LENGTH_BITS : POS_BITS;

   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX  = {LENGTH_BITS{1'b1}};
   localparam logic [7:0]             FAIL_SYMBOL = 8'd48;

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic {
      S_IDLE,
      S_WALK
   } state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  symbol_in;
      logic [15:0] position;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  symbol_out;
      logic [15:0] total_length;
      logic [6:0]  runs_in_use;
   } rsp_type;

   // Command token that walks the cell chain, one cell per cycle.
   typedef struct packed {
      logic                   valid;
      logic [1:0]             op;
      logic                   done;     // command has found its cell
      logic                   shift;    // later cells pull from their right neighbor
      logic                   changed;  // a run was opened or deleted
      logic [SLOT_BITS-1:0]   idx;      // runs left before the append slot
      logic [LENGTH_BITS-1:0] pos;      // position left to walk
      logic [7:0]             symbol;
   } token_type;

endpackage
`default_nettype wire

@@ design/rlis_cell.sv @@
// One run slot of the chain: holds a symbol and a count, acts on a passing token.
`timescale 1ns / 1ps
`default_nettype none
module rlis_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire rlis_pkg::token_type             tok_in,
   output rlis_pkg::token_type                  tok_out,
   input  wire logic [7:0]                      nbr_symbol,
   input  wire logic [rlis_pkg::LENGTH_BITS-1:0] nbr_count,
   output logic [7:0]                           my_symbol,
   output logic [rlis_pkg::LENGTH_BITS-1:0]     my_count
);

   logic [7:0]                       sym_ff, sym_in;
   logic [rlis_pkg::LENGTH_BITS-1:0] cnt_ff, cnt_in;
   rlis_pkg::token_type              tok_ff, tok_in_next;

   always_comb begin
      sym_in      = sym_ff;
      cnt_in      = cnt_ff;
      tok_in_next = tok_in;
      if (tok_in.valid) begin
         case (tok_in.op) inside
            rlis_pkg::CMD_APPEND: begin
               if (!tok_in.done) begin
                  if (tok_in.idx == rlis_pkg::SLOT_BITS'(1) && tok_in.symbol == sym_ff) begin
                     cnt_in           = cnt_ff + rlis_pkg::LENGTH_BITS'(1);
                     tok_in_next.done = 1'b1;
                  end else if (tok_in.idx == '0) begin
                     sym_in              = tok_in.symbol;
                     cnt_in              = rlis_pkg::LENGTH_BITS'(1);
                     tok_in_next.done    = 1'b1;
                     tok_in_next.changed = 1'b1;
                  end
               end
               if (tok_in.idx != '0) begin
                  tok_in_next.idx = tok_in.idx - rlis_pkg::SLOT_BITS'(1);
               end
            end
            rlis_pkg::CMD_READ, rlis_pkg::CMD_REMOVE: begin
               if (tok_in.shift) begin
                  // close the gap left by a deleted run
                  sym_in = nbr_symbol;
                  cnt_in = nbr_count;
               end else if (!tok_in.done) begin
                  if (tok_in.pos < cnt_ff) begin
                     tok_in_next.done   = 1'b1;
                     tok_in_next.symbol = sym_ff;
                     if (tok_in.op == rlis_pkg::CMD_REMOVE) begin
                        if (cnt_ff == rlis_pkg::LENGTH_BITS'(1)) begin
                           sym_in              = nbr_symbol;
                           cnt_in              = nbr_count;
                           tok_in_next.shift   = 1'b1;
                           tok_in_next.changed = 1'b1;
                        end else begin
                           cnt_in = cnt_ff - rlis_pkg::LENGTH_BITS'(1);
                        end
                     end
                  end else begin
                     tok_in_next.pos = tok_in.pos - cnt_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out   = tok_ff;
   assign my_symbol = sym_ff;
   assign my_count  = cnt_ff;

endmodule
`default_nettype wire

@@ design/run_length_indexed_store_top.sv @@
// Top level of the run-length indexed store: command control and the run cell chain.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Drive req_data and raise start; the command transfers at a rising edge with
//   start high and busy low. Commands: append a symbol, read the symbol at a
//   position, remove the symbol at a position. Every command gives one result
//   on rsp_data, marked by a one-cycle rsp_valid strobe; the receiver must take
//   it in that cycle, there is no stall on the result side.
//   Runs live in a chain of RUN_SLOTS cells, one run per cell. A command that
//   needs the table enters the chain as a token and moves one cell per cycle
//   through every cell of the chain before its result is shown, and busy stays high
//   meanwhile. Removing a run shifts later cells down as the token passes them.
//   Commands decided from the length and run count alone (out-of-range
//   position, full length, unused code) answer in the next cycle and leave
//   busy low, so those can follow every cycle.
//   Reset clears the length and run count; run cell contents are not cleared
//   and are only ever read once written. busy is held high during reset.
module run_length_indexed_store_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire rlis_pkg::req_type req_data,
   output logic                   rsp_valid,
   output rlis_pkg::rsp_type      rsp_data
);

   rlis_pkg::state_type              state_ff, state_in;
   logic [rlis_pkg::LENGTH_BITS-1:0] len_ff, len_in;
   logic [rlis_pkg::SLOT_BITS-1:0]   runs_ff, runs_in;
   rlis_pkg::token_type              inj_ff, inj_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   rlis_pkg::rsp_type                rsp_ff, rsp_in;

   logic                             accept;
   logic                             launch;
   logic [rlis_pkg::CMP_BITS-1:0]    pos_wide;
   logic [rlis_pkg::CMP_BITS-1:0]    len_wide;
   rlis_pkg::token_type              chain_out;

   // chain wiring: tok[i] enters cell i, tok[RUN_SLOTS] leaves the last cell
   rlis_pkg::token_type              tok   [rlis_pkg::RUN_SLOTS+1];
   logic [7:0]                       sym_w [rlis_pkg::RUN_SLOTS];
   logic [rlis_pkg::LENGTH_BITS-1:0] cnt_w [rlis_pkg::RUN_SLOTS];

   assign tok[0]    = inj_ff;
   assign chain_out = tok[rlis_pkg::RUN_SLOTS];

   for (genvar i = 0; i < rlis_pkg::RUN_SLOTS; i++) begin : g_cell
      logic [7:0]                       nbr_sym;
      logic [rlis_pkg::LENGTH_BITS-1:0] nbr_cnt;
      if (i == rlis_pkg::RUN_SLOTS - 1) begin : g_last
         assign nbr_sym = '0;
         assign nbr_cnt = '0;
      end else begin : g_mid
         assign nbr_sym = sym_w[i+1];
         assign nbr_cnt = cnt_w[i+1];
      end
      rlis_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .tok_in     (tok[i]),
         .tok_out    (tok[i+1]),
         .nbr_symbol (nbr_sym),
         .nbr_count  (nbr_cnt),
         .my_symbol  (sym_w[i]),
         .my_count   (cnt_w[i])
      );
   end

   assign accept   = start && !busy;
   assign pos_wide = rlis_pkg::CMP_BITS'(req_data.position);
   assign len_wide = rlis_pkg::CMP_BITS'(len_ff);

   // Decide whether the command needs the chain walk.
   always_comb begin
      launch = 1'b0;
      case (req_data.command) inside
         rlis_pkg::CMD_APPEND:                  launch = (len_ff != rlis_pkg::LENGTH_MAX);
         rlis_pkg::CMD_READ, rlis_pkg::CMD_REMOVE: launch = (pos_wide < len_wide);
         default:                               launch = 1'b0;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rlis_pkg::S_IDLE: if (accept && launch) state_in = rlis_pkg::S_WALK;
         rlis_pkg::S_WALK: if (chain_out.valid)  state_in = rlis_pkg::S_IDLE;
         default:          state_in = rlis_pkg::S_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      unique case (state_ff)
         rlis_pkg::S_IDLE: busy = reset;
         rlis_pkg::S_WALK: busy = 1'b1;
         default:          busy = 1'b1;
      endcase
   end

   // Datapath: launch tokens, retire them, build results.
   always_comb begin
      len_in       = len_ff;
      runs_in      = runs_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      inj_in       = '0;

      if (accept) begin
         if (launch) begin
            // inject the token into the first cell
            inj_in.valid  = 1'b1;
            inj_in.op     = req_data.command;
            inj_in.idx    = runs_ff;
            inj_in.pos    = rlis_pkg::LENGTH_BITS'(req_data.position);
            inj_in.symbol = req_data.symbol_in;
         end else begin
            // answer at once from the length and run count
            rsp_valid_in        = 1'b1;
            rsp_in.total_length = 16'(len_ff);
            rsp_in.runs_in_use  = 7'(runs_ff);
            case (req_data.command) inside
               rlis_pkg::CMD_APPEND: begin
                  rsp_in.status     = rlis_pkg::ST_FULL;
                  rsp_in.symbol_out = '0;
               end
               rlis_pkg::CMD_READ, rlis_pkg::CMD_REMOVE: begin
                  rsp_in.status     = rlis_pkg::ST_RANGE;
                  rsp_in.symbol_out = rlis_pkg::FAIL_SYMBOL;
               end
               default: begin
                  rsp_in.status     = rlis_pkg::ST_OK;
                  rsp_in.symbol_out = '0;
               end
            endcase
         end
      end

      if (chain_out.valid) begin
         rsp_valid_in      = 1'b1;
         rsp_in.status     = rlis_pkg::ST_OK;
         rsp_in.symbol_out = '0;
         case (chain_out.op) inside
            rlis_pkg::CMD_APPEND: begin
               if (chain_out.done) begin
                  len_in = len_ff + rlis_pkg::LENGTH_BITS'(1);
                  if (chain_out.changed) runs_in = runs_ff + rlis_pkg::SLOT_BITS'(1);
               end else begin
                  rsp_in.status = rlis_pkg::ST_FULL;
               end
            end
            rlis_pkg::CMD_READ: begin
               rsp_in.symbol_out = chain_out.symbol;
            end
            rlis_pkg::CMD_REMOVE: begin
               len_in = len_ff - rlis_pkg::LENGTH_BITS'(1);
               if (chain_out.changed) runs_in = runs_ff - rlis_pkg::SLOT_BITS'(1);
            end
            default: begin
            end
         endcase
         rsp_in.total_length = 16'(len_in);
         rsp_in.runs_in_use  = 7'(runs_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlis_pkg::S_IDLE;
         len_ff       <= '0;
         runs_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         inj_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         runs_ff      <= runs_in;
         rsp_valid_ff <= rsp_valid_in;
         inj_ff       <= inj_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ design/rlis_checker.sv @@
// Port-level checks for the run-length indexed store, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rlis_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire rlis_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire rlis_pkg::rsp_type rsp_data
);

   // a walk only begins with a command transfer
   a_busy_needs_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a command transfer");

   // the end of a walk always delivers its result
   a_walk_ends_in_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("walk ended without a result");

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_range_symbol: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == rlis_pkg::ST_RANGE) |->
         (rsp_data.symbol_out == rlis_pkg::FAIL_SYMBOL))
      else $error("out-of-range result without fail symbol");

   a_runs_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.runs_in_use <= 7'(rlis_pkg::RUN_SLOTS)))
      else $error("run count above slot count");

endmodule

bind run_length_indexed_store_top rlis_checker u_rlis_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire
